// ----- design/ilir_pkg.sv -----
// Shared constants, codes and the cell control type for the indexed list.
// No dependencies; used by every other file of the block.
`timescale 1ns / 1ps

package ilir_pkg;

	localparam int DEPTH_DEF  = 16;
	localparam int DATA_W_DEF = 32;

	// Wide enough to hold any index or length up to 2047.
	localparam int IDX_W      = 11;

	localparam int FUNC_W     = 3;
	localparam int POS_W      = 4;
	localparam int VALUE_W    = 32;
	localparam int COUNT_W    = 5;
	localparam int STATUS_W   = 2;

	localparam logic [FUNC_W-1:0] FN_READ   = 3'd0;
	localparam logic [FUNC_W-1:0] FN_APPEND = 3'd1;
	localparam logic [FUNC_W-1:0] FN_INSERT = 3'd2;
	localparam logic [FUNC_W-1:0] FN_POP    = 3'd3;
	localparam logic [FUNC_W-1:0] FN_REMOVE = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

	typedef struct packed {
		logic             ins_en;
		logic             rem_en;
		logic [IDX_W-1:0] pos;
		logic [IDX_W-1:0] cnt;
		logic [IDX_W-1:0] sel;
	} ilir_ctrl_t;

endpackage

// ----- design/ilir_cell.sv -----
// One storage cell of the list: holds a single entry and shifts to or from its neighbors.
// Depends on ilir_pkg for the control type and index width.
`timescale 1ns / 1ps

module ilir_cell #(
	parameter int DATA_WIDTH = ilir_pkg::DATA_W_DEF,
	parameter int INDEX      = 0
) (
	input  logic                    clk,
	input  ilir_pkg::ilir_ctrl_t    ctrl,
	input  logic [DATA_WIDTH-1:0]   new_data,
	input  logic [DATA_WIDTH-1:0]   lower_data,
	input  logic [DATA_WIDTH-1:0]   upper_data,
	output logic [DATA_WIDTH-1:0]   data,
	output logic [DATA_WIDTH-1:0]   hit_data
);

	localparam logic [ilir_pkg::IDX_W-1:0] Idx = ilir_pkg::IDX_W'(INDEX);

	logic [DATA_WIDTH-1:0] data_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins_en) begin
			if (Idx == ctrl.pos)
				data_q <= new_data;
			else if (Idx > ctrl.pos && Idx <= ctrl.cnt)
				data_q <= lower_data;
		end else if (ctrl.rem_en) begin
			if (Idx >= ctrl.pos && (Idx + 1'b1) < ctrl.cnt)
				data_q <= upper_data;
		end
	end

	assign data     = data_q;
	assign hit_data = (Idx == ctrl.sel) ? data_q : '0;

endmodule

// ----- design/indexed_list_insert_remove.sv -----
// Indexed list of up to DEPTH entries built from a row of shifting cells.
// Depends on ilir_pkg and ilir_cell.
`timescale 1ns / 1ps

// The block takes one request per clock cycle unless stalled: the cells shift the
// affected entries in the same edge that accepts the request, so insert and remove
// cost the same as read. The result is registered and appears in the cycle after
// acceptance; a new request is taken whenever that register is empty or being drained.
// Refused requests (full, empty, out of range) leave the list unchanged and return
// zero. Only the first 16 positions are addressable; count reports the low five bits.
module indexed_list_insert_remove #(
	parameter int DEPTH      = ilir_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = ilir_pkg::DATA_W_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  logic [ilir_pkg::FUNC_W-1:0]       func,
	input  logic [ilir_pkg::POS_W-1:0]        position,
	input  logic [ilir_pkg::VALUE_W-1:0]      value,
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output logic [ilir_pkg::VALUE_W-1:0]      read_value,
	output logic [ilir_pkg::COUNT_W-1:0]      count,
	output logic [ilir_pkg::STATUS_W-1:0]     status
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = ilir_pkg::IDX_W;

	logic [CW-1:0]                   count_q;
	logic                            rsp_valid_q;
	logic [ilir_pkg::VALUE_W-1:0]    read_value_q;
	logic [ilir_pkg::COUNT_W-1:0]    count_out_q;
	logic [ilir_pkg::STATUS_W-1:0]   status_q;

	logic                            acc;
	logic                            full;
	logic                            empty;
	logic                            rd_en;
	logic [IW-1:0]                   cnt_w;
	logic [IW-1:0]                   pos_w;
	logic [IW-1:0]                   cnt_nxt;
	logic [ilir_pkg::STATUS_W-1:0]   st;
	ilir_pkg::ilir_ctrl_t            ctrl;
	logic [DATA_WIDTH-1:0]           new_data;
	logic [DATA_WIDTH-1:0]           rd_or;
	logic [DATA_WIDTH-1:0]           cell_data [DEPTH];
	logic [DATA_WIDTH-1:0]           hit_data  [DEPTH];

	assign req_ready = !rsp_valid_q || rsp_ready;
	assign acc       = req_valid && req_ready;
	assign new_data  = DATA_WIDTH'(value);

	always_comb begin
		cnt_w    = IW'(count_q);
		pos_w    = IW'(position);
		full     = (cnt_w == IW'(DEPTH));
		empty    = (cnt_w == '0);
		ctrl     = '0;
		ctrl.pos = pos_w;
		ctrl.cnt = cnt_w;
		ctrl.sel = pos_w;
		rd_en    = 1'b0;
		st       = ilir_pkg::ST_OK;
		cnt_nxt  = cnt_w;
		case (func)
			ilir_pkg::FN_READ: begin
				if (empty)
					st = ilir_pkg::ST_EMPTY;
				else if (pos_w >= cnt_w)
					st = ilir_pkg::ST_RANGE;
				else
					rd_en = 1'b1;
			end
			ilir_pkg::FN_APPEND: begin
				if (full) begin
					st = ilir_pkg::ST_FULL;
				end else begin
					ctrl.ins_en = 1'b1;
					ctrl.pos    = cnt_w;
					cnt_nxt     = cnt_w + 1'b1;
				end
			end
			ilir_pkg::FN_INSERT: begin
				if (full) begin
					st = ilir_pkg::ST_FULL;
				end else if (pos_w > cnt_w) begin
					st = ilir_pkg::ST_RANGE;
				end else begin
					ctrl.ins_en = 1'b1;
					cnt_nxt     = cnt_w + 1'b1;
				end
			end
			ilir_pkg::FN_POP: begin
				if (empty) begin
					st = ilir_pkg::ST_EMPTY;
				end else begin
					rd_en       = 1'b1;
					ctrl.rem_en = 1'b1;
					ctrl.pos    = cnt_w - 1'b1;
					ctrl.sel    = cnt_w - 1'b1;
					cnt_nxt     = cnt_w - 1'b1;
				end
			end
			ilir_pkg::FN_REMOVE: begin
				if (empty) begin
					st = ilir_pkg::ST_EMPTY;
				end else if (pos_w >= cnt_w) begin
					st = ilir_pkg::ST_RANGE;
				end else begin
					rd_en       = 1'b1;
					ctrl.rem_en = 1'b1;
					cnt_nxt     = cnt_w - 1'b1;
				end
			end
			default: begin
				st = ilir_pkg::ST_OK;
			end
		endcase
		if (!acc) begin
			ctrl.ins_en = 1'b0;
			ctrl.rem_en = 1'b0;
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] lower;
		logic [DATA_WIDTH-1:0] upper;

		if (i == 0) begin : g_first
			assign lower = '0;
		end else begin : g_mid_lo
			assign lower = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign upper = '0;
		end else begin : g_mid_hi
			assign upper = cell_data[i+1];
		end

		ilir_cell #(
			.DATA_WIDTH (DATA_WIDTH),
			.INDEX      (i)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.new_data   (new_data),
			.lower_data (lower),
			.upper_data (upper),
			.data       (cell_data[i]),
			.hit_data   (hit_data[i])
		);
	end

	always_comb begin
		rd_or = '0;
		for (int i = 0; i < DEPTH; i++)
			rd_or = rd_or | hit_data[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				count_q     <= CW'(cnt_nxt);
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			read_value_q <= rd_en ? ilir_pkg::VALUE_W'(rd_or) : '0;
			count_out_q  <= ilir_pkg::COUNT_W'(cnt_nxt);
			status_q     <= st;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign read_value = read_value_q;
	assign count      = count_out_q;
	assign status     = status_q;

endmodule

// ----- design/ilir_checker.sv -----
// Port-level checks for the indexed list, attached to the top level by bind.
// Depends on ilir_pkg and on the port list of indexed_list_insert_remove.
`timescale 1ns / 1ps

module ilir_checker #(
	parameter int DEPTH = ilir_pkg::DEPTH_DEF
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              req_valid,
	input logic                              req_ready,
	input logic                              rsp_valid,
	input logic                              rsp_ready,
	input logic [ilir_pkg::VALUE_W-1:0]      read_value,
	input logic [ilir_pkg::COUNT_W-1:0]      count,
	input logic [ilir_pkg::STATUS_W-1:0]     status
);

	a_rsp_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> rsp_valid)
		else $error("no result after accepted item");

	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("item refused while output is free");

	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ilir_pkg::ST_OK |-> read_value == '0)
		else $error("refused item returned data");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && DEPTH < 32 |-> 32'(count) <= 32'(DEPTH))
		else $error("count beyond capacity");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_value) && $stable(count)
			&& $stable(status))
		else $error("stalled result changed");

endmodule

bind indexed_list_insert_remove ilir_checker #(.DEPTH(DEPTH)) u_ilir_checker (.*);
